// ===== rtl/ffua_pkg.sv =====
// ----------------------------------------------------------------------------
// ffua_pkg: shared types for the first-fit unit allocator
// Status codes, opcodes, controller states and the structs passed between
// the scan cells and the controller.
// ----------------------------------------------------------------------------
package ffua_pkg;

  localparam int BYTES_W  = 13;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 3;
  // Index and depth widths cover the largest supported pool of 256 units.
  localparam int IDX_W    = 9;
  localparam int DEPTH_W  = 10;

  localparam logic REG_POOL_BASE = 1'b0;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_FREED     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_SCAN,
    S_FINISH
  } state_t;

  // Scan token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic                       active;
    op_t                        op;
    logic [IDX_W-1:0]           want;
    logic [ADDR_W-1:0]          offset;
    logic signed [DEPTH_W-1:0]  depth;
    logic [IDX_W-1:0]           run_len;
    logic [IDX_W-1:0]           run_start;
    logic                       hit;
    logic                       found;
    logic [IDX_W-1:0]           found_idx;
    logic                       end_hit;
    logic [IDX_W-1:0]           end_idx;
  } token_t;

  // Mark update broadcast to all cells when a request completes.
  typedef struct packed {
    logic             start_we;
    logic             start_val;
    logic [IDX_W-1:0] start_idx;
    logic             end_we;
    logic             end_val;
    logic [IDX_W-1:0] end_idx;
  } commit_t;

endpackage

// ===== rtl/ffua_divider.sv =====
// ----------------------------------------------------------------------------
// ffua_divider: constant divider by the unit size
// Divides a byte count by UNIT_BYTES with a reciprocal multiplication that
// registers the quotient, then forms the remainder from the registered quotient.
// ----------------------------------------------------------------------------
module ffua_divider #(
  parameter int UNIT_BYTES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ffua_pkg::BYTES_W-1:0] dividend,
  output logic                         done,
  output logic [ffua_pkg::BYTES_W-1:0] quotient,
  output logic [ffua_pkg::BYTES_W-1:0] remainder
);
  import ffua_pkg::*;

  // The reciprocal is rounded up with enough fraction bits that the quotient
  // is exact for every dividend of BYTES_W bits.
  localparam int SHIFT  = BYTES_W + $clog2(UNIT_BYTES);
  localparam int PROD_W = 2 * BYTES_W + 1;
  localparam int BACK_W = 2 * BYTES_W;
  localparam logic [BYTES_W:0] RECIP =
    (BYTES_W + 1)'((2 ** SHIFT + UNIT_BYTES - 1) / UNIT_BYTES);
  localparam logic [BACK_W-1:0] DIVISOR = BACK_W'(UNIT_BYTES);

  logic               busy;
  logic [BYTES_W-1:0] dividend_q;
  logic [PROD_W-1:0]  product;
  logic [BACK_W-1:0]  back;

  assign product = PROD_W'(dividend) * PROD_W'(RECIP);
  assign back    = BACK_W'(quotient) * DIVISOR;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend_q <= dividend;
      quotient   <= BYTES_W'(product >> SHIFT);
    end else if (busy) begin
      remainder <= dividend_q - back[BYTES_W-1:0];
    end
  end

endmodule

// ===== rtl/ffua_cell.sv =====
// ----------------------------------------------------------------------------
// ffua_cell: one unit of the allocation pool
// Holds the start and end marks of one unit, advances the scan token by one
// unit and registers it toward the next cell.
// ----------------------------------------------------------------------------
module ffua_cell #(
  parameter int INDEX      = 0,
  parameter int UNIT_BYTES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  ffua_pkg::token_t  tk_in,
  input  ffua_pkg::commit_t commit,
  output ffua_pkg::token_t  tk_out
);
  import ffua_pkg::*;

  localparam logic [IDX_W-1:0]  MY_IDX    = IDX_W'(INDEX);
  localparam logic [IDX_W-1:0]  NEXT_IDX  = IDX_W'(INDEX + 1);
  localparam logic [ADDR_W-1:0] MY_OFFSET = ADDR_W'(INDEX * UNIT_BYTES);

  logic                      start_mark;
  logic                      end_mark;
  token_t                    tk_next;
  logic signed [DEPTH_W-1:0] depth_in;
  logic                      found_here;

  always_comb begin
    tk_next    = tk_in;
    depth_in   = tk_in.depth + {{(DEPTH_W-1){1'b0}}, start_mark};
    found_here = tk_in.found;
    if (tk_in.active && !tk_in.hit) begin
      unique case (tk_in.op)
        OP_ALLOC: begin
          // The unit is free only while no allocation is open around it.
          if (depth_in == '0) begin
            tk_next.run_len = tk_in.run_len + 1'b1;
          end else begin
            tk_next.run_len   = '0;
            tk_next.run_start = NEXT_IDX;
          end
          if (tk_next.run_len == tk_in.want) begin
            tk_next.hit     = 1'b1;
            tk_next.end_idx = MY_IDX;
          end else begin
            tk_next.depth = depth_in - {{(DEPTH_W-1){1'b0}}, end_mark};
          end
        end
        OP_FREE: begin
          if (!tk_in.found && tk_in.offset == MY_OFFSET) begin
            found_here        = 1'b1;
            tk_next.found     = 1'b1;
            tk_next.found_idx = MY_IDX;
          end
          if (found_here && end_mark) begin
            tk_next.end_hit = 1'b1;
            tk_next.end_idx = MY_IDX;
            tk_next.hit     = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tk_out.active <= 1'b0;
    end else begin
      tk_out <= tk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_mark <= 1'b0;
      end_mark   <= 1'b0;
    end else begin
      if (commit.start_we && commit.start_idx == MY_IDX) begin
        start_mark <= commit.start_val;
      end
      if (commit.end_we && commit.end_idx == MY_IDX) begin
        end_mark <= commit.end_val;
      end
    end
  end

endmodule

// ===== rtl/first_fit_unit_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_unit_allocator: first-fit allocator over a pool of fixed units
// Allocates and frees contiguous runs of units by start and end marks.
// ----------------------------------------------------------------------------
// Usage: a request enters on in_valid/in_stall with opcode, request_bytes and
// free_address; exactly one result per request leaves on out_valid/out_stall
// with status and block_address. pool_base is to be set over the APB port only
// while the block is idle; the block itself does not enforce this. pready is
// always high; reads with paddr[2] low return pool_base, other reads zero.
// The block works on one request at a time and holds in_stall high meanwhile.
// An allocate request first divides the size by UNIT_BYTES, then a scan token
// walks the row of NUM_UNITS cells, one unit per cycle. A free request skips
// the divider, and a bad size or an oversize request skips the scan. The next
// request is taken in the cycle after a result is loaded.
// The result sits in an output register, so a new request is accepted while
// the previous result waits; if the receiver stalls, the next result waits in
// the block until the output register frees up.
// Reset clears every mark, pool_base and out_valid.
// ----------------------------------------------------------------------------
module first_fit_unit_allocator #(
  parameter int NUM_UNITS  = 16,
  parameter int UNIT_BYTES = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [ffua_pkg::BYTES_W-1:0]  request_bytes,
  input  logic [ffua_pkg::ADDR_W-1:0]   free_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ffua_pkg::status_t             status,
  output logic [ffua_pkg::ADDR_W-1:0]   block_address
);
  import ffua_pkg::*;

  localparam logic [ADDR_W-1:0]  UNIT_SIZE = ADDR_W'(UNIT_BYTES);
  localparam logic [BYTES_W-1:0] MAX_UNITS = BYTES_W'(NUM_UNITS);

  state_t             state;
  state_t             state_next;
  logic [31:0]        pool_base;
  op_t                op_q;
  logic [IDX_W-1:0]   want_q;
  logic [ADDR_W-1:0]  offset_q;
  logic               launch;
  logic               launch_next;
  logic               skip_scan;
  status_t            pre_status;
  token_t             fin;
  token_t             tk_chain [NUM_UNITS+1];
  commit_t            commit;
  logic               in_accept;
  logic               div_start;
  logic               div_done;
  logic [BYTES_W-1:0] quotient;
  logic [BYTES_W-1:0] remainder;
  logic               size_bad;
  logic               size_big;
  logic               out_load;
  status_t            res_status;
  logic [ADDR_W-1:0]  res_address;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POOL_BASE) ? pool_base : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_POOL_BASE) begin
      pool_base <= pwdata;
    end
  end

  ffua_divider #(
    .UNIT_BYTES(UNIT_BYTES)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (request_bytes),
    .done     (div_done),
    .quotient (quotient),
    .remainder(remainder)
  );

  assign size_bad = (remainder != '0) || (quotient == '0);
  assign size_big = (quotient > MAX_UNITS);

  // Seed token entering the first cell.
  always_comb begin
    tk_chain[0]           = '0;
    tk_chain[0].active    = launch;
    tk_chain[0].op        = op_q;
    tk_chain[0].want      = want_q;
    tk_chain[0].offset    = offset_q;
  end

  for (genvar i = 0; i < NUM_UNITS; i++) begin : g_cell
    ffua_cell #(
      .INDEX     (i),
      .UNIT_BYTES(UNIT_BYTES)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .tk_in (tk_chain[i]),
      .commit(commit),
      .tk_out(tk_chain[i+1])
    );
  end

  assign in_accept = in_valid && !in_stall;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = (op_t'(opcode) == OP_FREE) ? S_SCAN : S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (div_done) begin
          state_next = (size_bad || size_big) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (tk_chain[NUM_UNITS].active) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Controller outputs and result selection.
  always_comb begin
    in_stall    = (state != S_IDLE);
    div_start   = (state == S_IDLE) && in_accept && (op_t'(opcode) == OP_ALLOC);
    launch_next = 1'b0;
    out_load    = 1'b0;
    commit      = '0;
    res_status  = pre_status;
    res_address = '0;
    unique case (state)
      S_IDLE: begin
        launch_next = in_accept && (op_t'(opcode) == OP_FREE);
      end
      S_DIVIDE: begin
        launch_next = div_done && !size_bad && !size_big;
      end
      S_SCAN: ;
      S_FINISH: begin
        out_load = !out_valid || !out_stall;
        if (!skip_scan) begin
          unique case (fin.op)
            OP_ALLOC: begin
              if (fin.hit) begin
                res_status       = ST_ALLOCATED;
                res_address      = pool_base + ADDR_W'(fin.run_start) * UNIT_SIZE;
                commit.start_we  = out_load;
                commit.start_val = 1'b1;
                commit.start_idx = fin.run_start;
                commit.end_we    = out_load;
                commit.end_val   = 1'b1;
                commit.end_idx   = fin.end_idx;
              end else begin
                res_status = ST_NO_SPACE;
              end
            end
            OP_FREE: begin
              if (fin.found) begin
                res_status       = ST_FREED;
                commit.start_we  = out_load;
                commit.start_val = 1'b0;
                commit.start_idx = fin.found_idx;
                commit.end_we    = out_load && fin.end_hit;
                commit.end_val   = 1'b0;
                commit.end_idx   = fin.end_idx;
              end else begin
                res_status = ST_NOT_FOUND;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      launch    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= launch_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q      <= op_t'(opcode);
      offset_q  <= free_address - pool_base;
      skip_scan <= 1'b0;
    end
    if (state == S_DIVIDE && div_done) begin
      want_q     <= quotient[IDX_W-1:0];
      skip_scan  <= size_bad || size_big;
      pre_status <= size_bad ? ST_BAD_SIZE : ST_NO_SPACE;
    end
    if (state == S_SCAN && tk_chain[NUM_UNITS].active) begin
      fin <= tk_chain[NUM_UNITS];
    end
    if (out_load) begin
      status        <= res_status;
      block_address <= res_address;
    end
  end

endmodule
